/* design/aes_block_cipher_defines.svh */
// Assertion macros for the AES block cipher.
// No dependencies; included by the top level only.
`ifndef AES_BLOCK_CIPHER_DEFINES_SVH
`define AES_BLOCK_CIPHER_DEFINES_SVH

// same-cycle implication
`define AES_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define AES_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/aes_pkg.sv */
// Shared types, constants and byte functions for the AES block cipher.
// No dependencies; used by aes_round, aes_key_sched and aes_block_cipher.
package aes_pkg;

    localparam int BLOCK_COLUMNS   = 4;
    localparam int ROUND_KEY_WORDS = 60;
    localparam int KEY_ROWS        = ROUND_KEY_WORDS / BLOCK_COLUMNS;

    localparam logic [2:0] CFG_KEY_SIZE   = 3'd0;
    localparam logic [2:0] CFG_KEY_BITS_0 = 3'd1;
    localparam logic [2:0] CFG_KEY_BITS_1 = 3'd2;
    localparam logic [2:0] CFG_KEY_BITS_2 = 3'd3;
    localparam logic [2:0] CFG_KEY_BITS_3 = 3'd4;

    localparam logic [1:0] KSIZE_128 = 2'd0;
    localparam logic [1:0] KSIZE_192 = 2'd1;

    localparam logic [7:0] GF_POLY = 8'h1b;

    typedef struct packed {
        logic       busy;
        logic [3:0] num_rounds;
    } aes_key_stat_t;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] SBOX_REV [0:255] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // one column of MixColumns, row 0 in the top byte
    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        mix_col = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                   a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                   a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                   xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
    endfunction

    function automatic logic [7:0] mul9(input logic [7:0] a);
        mul9 = xtime(xtime(xtime(a))) ^ a;
    endfunction

    function automatic logic [7:0] mul11(input logic [7:0] a);
        mul11 = xtime(xtime(xtime(a))) ^ xtime(a) ^ a;
    endfunction

    function automatic logic [7:0] mul13(input logic [7:0] a);
        mul13 = xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ a;
    endfunction

    function automatic logic [7:0] mul14(input logic [7:0] a);
        mul14 = xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ xtime(a);
    endfunction

    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        inv_mix_col = {mul14(a0) ^ mul11(a1) ^ mul13(a2) ^ mul9(a3),
                       mul9(a0) ^ mul14(a1) ^ mul11(a2) ^ mul13(a3),
                       mul13(a0) ^ mul9(a1) ^ mul14(a2) ^ mul11(a3),
                       mul11(a0) ^ mul13(a1) ^ mul9(a2) ^ mul14(a3)};
    endfunction

endpackage

/* design/aes_round.sv */
// One full AES round, forward or inverse, shared by every round of a block.
// Depends on aes_pkg.
module aes_round (
    input  logic         dec,
    input  logic         last,
    input  logic [127:0] state_in,
    input  logic [127:0] rkey,
    output logic [127:0] state_out
);

    logic [7:0]   st    [0:15];
    logic [7:0]   sh    [0:15];
    logic [127:0] sh_flat;
    logic [127:0] mixed;
    logic [127:0] keyed;

    always_comb
    begin
        for (int b = 0; b < 16; b++)
        begin
            st[b] = state_in[127 - 8*b -: 8];
        end
        // byte c*4+r sits in column c, row r
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (dec)
                    sh[((c + r) % 4) * 4 + r] = aes_pkg::SBOX_REV[st[c*4 + r]];
                else
                    sh[c*4 + r] = aes_pkg::SBOX[st[((c + r) % 4) * 4 + r]];
            end
        end
        for (int b = 0; b < 16; b++)
        begin
            sh_flat[127 - 8*b -: 8] = sh[b];
        end
    end

    always_comb
    begin
        if (dec)
        begin
            // inverse order: add key, then InvMixColumns
            keyed = sh_flat ^ rkey;
            for (int c = 0; c < 4; c++)
            begin
                mixed[127 - 32*c -: 32] = aes_pkg::inv_mix_col(keyed[127 - 32*c -: 32]);
            end
            state_out = last ? keyed : mixed;
        end
        else
        begin
            for (int c = 0; c < 4; c++)
            begin
                mixed[127 - 32*c -: 32] = aes_pkg::mix_col(sh_flat[127 - 32*c -: 32]);
            end
            keyed = (last ? sh_flat : mixed) ^ rkey;
            state_out = keyed;
        end
    end

endmodule

/* design/aes_key_sched.sv */
// Key registers, key expansion sequencer (one word per cycle) and round key store.
// Depends on aes_pkg.
module aes_key_sched (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_data,
    input  logic [3:0]            rd_addr,
    output logic [127:0]          rd_key,
    output aes_pkg::aes_key_stat_t stat
);

    logic [1:0]   key_size_reg;
    logic [255:0] key_reg;
    logic         busy_reg;
    logic [5:0]   idx_reg;
    logic [2:0]   mod_reg;
    logic [7:0]   rc_reg;
    logic [31:0]  win_reg [0:7];
    logic [31:0]  rd_q_reg [0:3];
    logic [31:0]  rk_mem [0:3][0:aes_pkg::KEY_ROWS-1];

    logic [31:0]  key_words [0:7];
    logic [2:0]   nk_m1;
    logic [5:0]   last_idx;
    logic [3:0]   nr;
    logic         start;
    logic [31:0]  temp;
    logic [31:0]  new_word;
    logic         expanding;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            key_words[k] = key_reg[255 - 32*k -: 32];
        end
        case (key_size_reg)
            aes_pkg::KSIZE_128:
            begin
                nk_m1 = 3'd3; last_idx = 6'd43; nr = 4'd10;
            end
            aes_pkg::KSIZE_192:
            begin
                nk_m1 = 3'd5; last_idx = 6'd51; nr = 4'd12;
            end
            default:
            begin
                nk_m1 = 3'd7; last_idx = 6'd59; nr = 4'd14;
            end
        endcase
    end

    always_comb
    begin
        case (cfg_index)
            aes_pkg::CFG_KEY_SIZE,
            aes_pkg::CFG_KEY_BITS_0,
            aes_pkg::CFG_KEY_BITS_1,
            aes_pkg::CFG_KEY_BITS_2,
            aes_pkg::CFG_KEY_BITS_3: start = cfg_valid;
            default:                 start = 1'b0;
        endcase
    end

    // the first Nk words come straight from the key
    assign expanding = (idx_reg > {3'd0, nk_m1});

    always_comb
    begin
        temp = win_reg[0];
        if (mod_reg == 3'd0)
            temp = aes_pkg::sub_word({win_reg[0][23:0], win_reg[0][31:24]}) ^ {rc_reg, 24'd0};
        else if (nk_m1 == 3'd7 && mod_reg == 3'd4)
            temp = aes_pkg::sub_word(win_reg[0]);
        new_word = expanding ? (win_reg[nk_m1] ^ temp) : key_words[idx_reg[2:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_size_reg <= '0;
            key_reg      <= '0;
            busy_reg     <= 1'b0;
            idx_reg      <= '0;
            mod_reg      <= '0;
            rc_reg       <= 8'h01;
        end
        else if (start)
        begin
            case (cfg_index)
                aes_pkg::CFG_KEY_SIZE:   key_size_reg      <= cfg_data[1:0];
                aes_pkg::CFG_KEY_BITS_0: key_reg[255:192]  <= cfg_data;
                aes_pkg::CFG_KEY_BITS_1: key_reg[191:128]  <= cfg_data;
                aes_pkg::CFG_KEY_BITS_2: key_reg[127:64]   <= cfg_data;
                default:                 key_reg[63:0]     <= cfg_data;
            endcase
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            mod_reg  <= '0;
            rc_reg   <= 8'h01;
        end
        else if (busy_reg)
        begin
            idx_reg  <= idx_reg + 6'd1;
            mod_reg  <= (mod_reg == nk_m1) ? 3'd0 : mod_reg + 3'd1;
            if (expanding && mod_reg == 3'd0)
                rc_reg <= aes_pkg::xtime(rc_reg);
            if (idx_reg == last_idx)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !start)
        begin
            win_reg[0] <= new_word;
            for (int k = 1; k < 8; k++)
            begin
                win_reg[k] <= win_reg[k-1];
            end
            rk_mem[idx_reg[1:0]][idx_reg[5:2]] <= new_word;
        end
        for (int c = 0; c < 4; c++)
        begin
            rd_q_reg[c] <= rk_mem[c][rd_addr];
        end
    end

    assign rd_key          = {rd_q_reg[0], rd_q_reg[1], rd_q_reg[2], rd_q_reg[3]};
    assign stat.busy       = busy_reg;
    assign stat.num_rounds = nr;

endmodule

/* design/aes_block_cipher.sv */
// AES-128/192/256 block cipher, one round per clock on a shared round unit; the last
// round waits while out_free is low. Depends on aes_pkg, aes_round, aes_key_sched
// and aes_block_cipher_defines.svh.
// For a block, the first round key is fetched from the key store on the accept
// edge, the initial key add follows in ST_INIT, then each round passes
// through the round unit in ST_RUN. Any write to key_size or key_bits_* starts a key
// expansion that produces one round key word per cycle (44, 52 or 60 words for 128,
// 192 and 256 bit keys); in_ready stays low until it finishes. The finished word
// sits in an output register, so the next block can be taken meanwhile.
module aes_block_cipher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [63:0] block_hi,
    input  logic [63:0] block_lo,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] result_hi,
    output logic [63:0] result_lo
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_INIT = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    logic [1:0]   seq_reg, seq_next;
    logic [3:0]   round_reg, round_next;
    logic         dec_reg, dec_next;
    logic [127:0] state_reg, state_next;
    logic         out_valid_reg, out_valid_next;
    logic [127:0] result_reg, result_next;

    aes_pkg::aes_key_stat_t kstat;
    logic [127:0] rkey;
    logic [127:0] round_out;
    logic         last;
    logic         accept;
    logic         out_free;

    aes_key_sched u_key_sched (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rd_addr   (round_next),
        .rd_key    (rkey),
        .stat      (kstat)
    );

    aes_round u_round (
        .dec       (dec_reg),
        .last      (last),
        .state_in  (state_reg),
        .rkey      (rkey),
        .state_out (round_out)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (seq_reg == ST_IDLE) && !kstat.busy;
    assign accept    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign last      = dec_reg ? (round_reg == 4'd0) : (round_reg == kstat.num_rounds);

    always_comb
    begin
        seq_next       = seq_reg;
        round_next     = round_reg;
        dec_next       = dec_reg;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        result_next    = result_reg;
        case (seq_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = {block_hi, block_lo};
                    dec_next   = req_type;
                    round_next = req_type ? kstat.num_rounds : 4'd0;
                    seq_next   = ST_INIT;
                end
            end
            ST_INIT:
            begin
                state_next = state_reg ^ rkey;
                round_next = dec_reg ? round_reg - 4'd1 : round_reg + 4'd1;
                seq_next   = ST_RUN;
            end
            ST_RUN:
            begin
                if (!last)
                begin
                    state_next = round_out;
                    round_next = dec_reg ? round_reg - 4'd1 : round_reg + 4'd1;
                end
                else if (out_free)
                begin
                    result_next    = round_out;
                    out_valid_next = 1'b1;
                    seq_next       = ST_IDLE;
                end
            end
            default:
            begin
                seq_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= ST_IDLE;
            round_reg     <= '0;
            dec_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            seq_reg       <= seq_next;
            round_reg     <= round_next;
            dec_reg       <= dec_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result_hi = result_reg[127:64];
    assign result_lo = result_reg[63:0];

`include "aes_block_cipher_defines.svh"

    `AES_ASSERT_NEXT(a_accept_init, accept, seq_reg == ST_INIT, "accept did not start init")
    `AES_ASSERT_NOW(a_round_range, seq_reg == ST_RUN, round_reg <= kstat.num_rounds, "round out of range")
    `AES_ASSERT_NOW(a_out_from_run, $rose(out_valid_reg), $past(seq_reg) == ST_RUN, "stray result word")

endmodule
